// File: rtl/core/sha256_stream_hasher_macros.svh
// Assertion macros for the SHA-256 stream hasher checker
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/core/shs_pkg.sv
// Types and constants shared by the SHA-256 stream hasher
package shs_pkg;
	typedef enum logic [0:0] {
		ACT_ABSORB = 1'b0,
		ACT_FINISH = 1'b1
	} action_t;

	typedef struct packed {
		logic        finish;
		logic [7:0]  data;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PAD,
		BK_ROUND,
		BK_ADD,
		BK_EMIT
	} bk_state_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// File: rtl/core/shs_queue.sv
// Small item queue between the front and the hashing core
module shs_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  shs_pkg::entry_t in_entry,
	output logic           out_valid,
	input  logic           out_take,
	output shs_pkg::entry_t out_entry
);
	import shs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t         mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;
	logic           push;
	logic           pop;

	assign in_stall  = (cnt_q == (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_entry = mem_q[rd_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && out_take;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: rtl/core/shs_core.sv
// Block buffer, padding, 64-round compression and digest output
module shs_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_take,
	input  shs_pkg::entry_t in_entry,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     digest_word,
	output logic            last_word
);
	import shs_pkg::*;

	bk_state_t   state_q;
	bk_state_t   state_nx;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic [3:0]  rnd_w_q;
	logic        final_q;
	logic [5:0]  pad_q;
	logic        pad_two_q;
	logic [2:0]  emit_q;

	logic        absorb;
	logic        finish;
	logic        block_done;
	logic [31:0] wt;
	logic [31:0] s0;
	logic [31:0] s1;
	logic [31:0] wn;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] big0;
	logic [31:0] big1;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [7:0]  pad_byte;
	logic [2:0]  len_idx;
	logic        by_we;
	logic [5:0]  by_idx;
	logic [7:0]  by_val;

	assign absorb = (state_q == BK_IDLE) && in_valid && !in_entry.finish;
	assign finish = (state_q == BK_IDLE) && in_valid && in_entry.finish;
	assign in_take = (state_q == BK_IDLE) && in_valid;
	assign block_done = absorb && (fill_q == 6'd63);

	assign wt   = w_q[rnd_w_q];
	assign s0   = rotr(w_q[4'(rnd_w_q + 4'd1)], 7) ^ rotr(w_q[4'(rnd_w_q + 4'd1)], 18)
		^ (w_q[4'(rnd_w_q + 4'd1)] >> 3);
	assign s1   = rotr(w_q[4'(rnd_w_q + 4'd14)], 17) ^ rotr(w_q[4'(rnd_w_q + 4'd14)], 19)
		^ (w_q[4'(rnd_w_q + 4'd14)] >> 10);
	assign wn   = s1 + w_q[4'(rnd_w_q + 4'd9)] + s0 + wt;
	assign big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1   = v_q[7] + big1 + ch + K_TAB[rnd_q] + wt;
	assign t2   = big0 + maj;

	assign len_idx = pad_q[2:0];
	always_comb begin
		if (pad_two_q || pad_q < 6'd56) begin
			pad_byte = 8'h00;
		end else begin
			pad_byte = 8'(total_q >> (6'd56 - {len_idx, 3'b000}));
		end
	end

	always_comb begin
		by_we  = absorb || finish || (state_q == BK_PAD);
		by_idx = (state_q == BK_PAD) ? pad_q : fill_q;
		if (absorb) begin
			by_val = in_entry.data;
		end else if (finish) begin
			by_val = 8'h80;
		end else begin
			by_val = pad_byte;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (block_done) begin
					state_nx = BK_ROUND;
				end else if (finish) begin
					state_nx = (fill_q == 6'd63) ? BK_ROUND : BK_PAD;
				end
			end
			BK_PAD: begin
				if (pad_q == 6'd63) begin
					state_nx = BK_ROUND;
				end
			end
			BK_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_nx = BK_ADD;
				end
			end
			BK_ADD: begin
				if (!final_q) begin
					state_nx = BK_IDLE;
				end else if (pad_two_q) begin
					state_nx = BK_PAD;
				end else begin
					state_nx = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!out_stall && emit_q == 3'd7) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		out_valid   = (state_q == BK_EMIT);
		digest_word = h_q[emit_q];
		last_word   = (emit_q == 3'd7);
	end

	always_ff @(posedge clk) begin
		if (by_we) begin
			w_q[by_idx[5:2]][{~by_idx[1:0], 3'b000} +: 8] <= by_val;
		end
		if (finish) begin
			total_q <= bits_q + {55'd0, fill_q, 3'b000};
		end
		if ((state_q == BK_IDLE && state_nx == BK_ROUND) || (state_q == BK_PAD && pad_q == 6'd63)) begin
			rnd_w_q <= '0;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == BK_ROUND) begin
			w_q[rnd_w_q] <= wn;
			rnd_w_q <= rnd_w_q + 4'd1;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			fill_q    <= '0;
			bits_q    <= '0;
			rnd_q     <= '0;
			final_q   <= 1'b0;
			pad_q     <= '0;
			pad_two_q <= 1'b0;
			emit_q    <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			state_q <= state_nx;
			if (absorb) begin
				fill_q <= fill_q + 6'd1;
				final_q <= 1'b0;
				if (fill_q == 6'd63) begin
					bits_q <= bits_q + 64'd512;
				end
			end else if (finish) begin
				final_q   <= 1'b1;
				pad_q     <= fill_q + 6'd1;
				pad_two_q <= (fill_q >= 6'd56);
			end
			if (state_q == BK_PAD) begin
				pad_q <= pad_q + 6'd1;
			end
			if (state_q == BK_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == BK_ADD) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
				if (pad_two_q) begin
					pad_two_q <= 1'b0;
					pad_q     <= '0;
				end
				emit_q <= '0;
			end
			if (state_q == BK_EMIT && !out_stall) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= H_INIT[i];
					end
					fill_q  <= '0;
					bits_q  <= '0;
					final_q <= 1'b0;
				end
			end
		end
	end
endmodule

// File: rtl/core/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher
// Items pass through a four-entry queue into the hashing core. The 64th
// byte of a block starts 64 rounds and then the chaining add; the core takes
// no new byte until that is done. A finish pads the rest of the block at one
// byte a cycle, runs one or two compressions (a second one follows a block
// of padding), then presents eight digest words, one a cycle while not
// stalled. The single round unit sets the rate.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        last_word
);
	import shs_pkg::*;

	entry_t q_in;
	entry_t q_out;
	logic   q_valid;
	logic   q_take;

	assign q_in.finish = (action == ACT_FINISH);
	assign q_in.data   = byte_value;

	shs_queue #(.DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_entry(q_in),
		.out_valid(q_valid), .out_take(q_take), .out_entry(q_out)
	);

	shs_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_take(q_take), .in_entry(q_out),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .last_word(last_word)
	);
endmodule

// File: rtl/core/shs_checker.sv
// Port checker for the SHA-256 stream hasher, bound to the top level
`include "sha256_stream_hasher_macros.svh"
module shs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic        last_word
);
	`SHS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid)
	`SHS_ASSERT_IMPL(a_out_known, clk, arst_n, out_valid, !$isunknown({digest_word, last_word}))
	`SHS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(digest_word) && $stable(last_word))
	`SHS_ASSERT_NEXT(a_last_gap, clk, arst_n, out_valid && !out_stall && last_word, !out_valid)
	`SHS_ASSERT_NEXT(a_no_early_last, clk, arst_n, out_valid && !out_stall && !last_word, out_valid)
endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.digest_word(digest_word), .last_word(last_word)
);

// File: verif/testbench.sv
// Testbench for the SHA-256 stream hasher: directed table, random messages, digest predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import shs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  byte_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic        last_word;

	sha256_stream_hasher dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .byte_value(byte_value), .out_valid(out_valid),
		.out_stall(out_stall), .digest_word(digest_word), .last_word(last_word)
	);

	typedef struct {
		logic [31:0] word;
		logic        last;
	} digest_out_t;

	typedef struct {
		action_t     act;
		logic [7:0]  data;
		logic        typed;
		logic [31:0] first_word;
	} stim_row_t;

	logic [31:0] hash_words [8];
	logic [7:0]  blk [64];
	int unsigned fill;
	logic [63:0] bit_total;
	digest_out_t pending_words [$];
	int          errors;
	int          in_idle_pct;
	int          out_stall_pct;
	bit          hold_off;
	stim_row_t   typed_first [$];

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, e, a;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		v = hash_words;
		for (int i = 0; i < 64; i++) begin
			e = v[4];
			a = v[0];
			t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
				+ RK[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_words[i] += v[i];
	endtask

	task automatic hash_item(action_t act, logic [7:0] data);
		logic [63:0] total;
		digest_out_t d;
		if (act == ACT_ABSORB) begin
			blk[fill] = data;
			fill = (fill + 1) % 64;
			if (fill == 0) begin
				compress();
				bit_total += 64'd512;
			end
			return;
		end
		total = bit_total + 64'(fill) * 8;
		blk[fill] = 8'h80;
		fill++;
		if (fill > 56) begin
			while (fill < 64) blk[fill++] = 8'h00;
			compress();
			fill = 0;
		end
		while (fill < 56) blk[fill++] = 8'h00;
		for (int i = 0; i < 8; i++)
			blk[56+i] = total[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			d.word = hash_words[i];
			d.last = (i == 7);
			pending_words.push_back(d);
		end
		hash_words = IV;
		fill = 0;
		bit_total = '0;
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic send(action_t act, logic [7:0] data);
		logic [7:0] bv;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			action <= 1'($urandom);
			byte_value <= 8'($urandom);
			@(posedge clk);
		end
		bv = (act == ACT_FINISH) ? 8'($urandom) : data;
		in_valid <= 1'b1;
		action <= act;
		byte_value <= bv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hash_item(act, bv);
	endtask

	task automatic send_message(int len, int kind);
		for (int i = 0; i < len; i++)
			send(ACT_ABSORB, kind == 0 ? 8'($urandom) : (kind == 1 ? 8'hff : 8'h00));
		send(ACT_FINISH, 8'h00);
	endtask

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off)
				out_stall <= 1'b1;
			else
				out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	always @(posedge clk) begin
		digest_out_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report("unexpected word", digest_word, 32'h0);
			end else begin
				w = pending_words.pop_front();
				if (digest_word !== w.word) report("digest_word", digest_word, w.word);
				if (last_word !== w.last) report("last_word", 32'(last_word), 32'(w.last));
				if (w.last == 1'b0 && pending_words.size() % 8 == 7 && typed_first.size() > 0) begin
					if (typed_first[0].typed && w.word !== typed_first[0].first_word)
						report("typed digest", w.word, typed_first[0].first_word);
					void'(typed_first.pop_front());
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		int phase_idle [4] = '{0, 58, 0, 34};
		int phase_stall [4] = '{0, 0, 58, 34};
		int n;
		errors = 0;
		hash_words = IV;
		fill = 0;
		bit_total = '0;
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_off = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		byte_value = 8'h00;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, "abc", extremes and a 55/56-byte padding boundary
		rows.push_back('{ACT_FINISH, 8'h00, 1'b1, 32'he3b0c442});
		rows.push_back('{ACT_ABSORB, 8'h61, 1'b0, 32'h0});
		rows.push_back('{ACT_ABSORB, 8'h62, 1'b0, 32'h0});
		rows.push_back('{ACT_ABSORB, 8'h63, 1'b0, 32'h0});
		rows.push_back('{ACT_FINISH, 8'hff, 1'b1, 32'hba7816bf});
		rows.push_back('{ACT_ABSORB, 8'h00, 1'b0, 32'h0});
		rows.push_back('{ACT_ABSORB, 8'hff, 1'b0, 32'h0});
		rows.push_back('{ACT_ABSORB, 8'h80, 1'b0, 32'h0});
		rows.push_back('{ACT_ABSORB, 8'h7f, 1'b0, 32'h0});
		rows.push_back('{ACT_FINISH, 8'h55, 1'b0, 32'h0});
		rows.push_back('{ACT_FINISH, 8'haa, 1'b1, 32'he3b0c442});
		foreach (rows[i]) begin
			r = rows[i];
			if (r.act == ACT_FINISH) typed_first.push_back(r);
			send(r.act, r.data);
		end
		send_message(55, 0);
		send_message(56, 1);
		send_message(63, 2);
		send_message(64, 0);

		hold_off = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int k = 0; k < 4; k++) send_message($urandom_range(0, 3), 0);
				in_valid <= 1'b0;
				@(posedge clk);
			end
		join

		n = 0;
		for (int ph = 0; ph < 4; ph++) begin
			in_idle_pct = phase_idle[ph];
			out_stall_pct = phase_stall[ph];
			while (n < 30 * (ph + 1)) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 12);
				send_message(len, 0);
				n += len + 1;
			end
		end
		in_valid <= 1'b0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		while (pending_words.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0 && typed_first.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
